// ----- hw/rtl/elx_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character classes and the per-character lexing function.
package elx_pkg;

  // Depth of the result queue; two slots must be free before an item is processed.
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);

  localparam logic [1:0] KIND_OP     = 2'd0;
  localparam logic [1:0] KIND_DSTAR  = 2'd1;
  localparam logic [1:0] KIND_NUMBER = 2'd2;
  localparam logic [1:0] KIND_IDENT  = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DOTS = 2'd1;
  localparam logic [1:0] ERR_CHAR = 2'd2;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_NUM  = 3'b010,
    MODE_ID   = 3'b100
  } scan_mode_t;

  typedef struct packed {
    logic       tok_valid;
    logic [7:0] ch;
    logic [1:0] kind;
    logic       tok_start;
    logic       tok_end;
    logic [1:0] err;
    logic       tend;
    logic       rlast;
  } res_item_t;

  typedef struct packed {
    logic [1:0] err;
    logic [1:0] cnt;
    res_item_t  it0;
    res_item_t  it1;
    scan_mode_t mode;
    logic       dot;
    logic       ate;
  } lex_res_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29) || (c == 8'h2B) || (c == 8'h2D) ||
           (c == CH_STAR) || (c == 8'h2F) || (c == 8'h5E) || (c == 8'h3D) ||
           (c == 8'h2C) || (c == 8'h21);
  endfunction

  function automatic logic num_cont(logic [7:0] c);
    return is_digit(c) || (c == CH_DOT);
  endfunction

  function automatic logic id_cont(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic res_item_t make_tok(logic [7:0] c, logic [1:0] kind, logic st,
                                         logic en);
    res_item_t t;
    t           = '0;
    t.tok_valid = 1'b1;
    t.ch        = c;
    t.kind      = kind;
    t.tok_start = st;
    t.tok_end   = en;
    return t;
  endfunction

  // Lexes one character h given the scan state and an optional lookahead nx.
  function automatic lex_res_t lex_char(scan_mode_t mode, logic dot, logic [7:0] h,
                                        logic has_next, logic [7:0] nx);
    lex_res_t r;
    logic     num_more;
    logic     id_more;
    r        = '0;
    r.mode   = mode;
    r.dot    = dot;
    num_more = has_next && num_cont(nx);
    id_more  = has_next && id_cont(nx);
    case (mode)
      MODE_NUM: begin
        if ((h == CH_DOT) && dot) begin
          r.err = ERR_DOTS;
        end else begin
          if (h == CH_DOT) r.dot = 1'b1;
          r.cnt = 2'd1;
          r.it0 = make_tok(h, KIND_NUMBER, 1'b0, !num_more);
          if (!num_more) begin
            r.mode = MODE_IDLE;
            r.dot  = 1'b0;
          end
        end
      end
      MODE_ID: begin
        r.cnt = 2'd1;
        r.it0 = make_tok(h, KIND_IDENT, 1'b0, !id_more);
        if (!id_more) begin
          r.mode = MODE_IDLE;
          r.dot  = 1'b0;
        end
      end
      default: begin
        if (is_space(h)) begin
          r.cnt = 2'd0;
        end else if ((h == CH_STAR) && has_next && (nx == CH_STAR)) begin
          r.cnt = 2'd2;
          r.it0 = make_tok(CH_STAR, KIND_DSTAR, 1'b1, 1'b0);
          r.it1 = make_tok(CH_STAR, KIND_DSTAR, 1'b0, 1'b1);
          r.ate = 1'b1;
        end else if (is_op(h)) begin
          r.cnt = 2'd1;
          r.it0 = make_tok(h, KIND_OP, 1'b1, 1'b1);
        end else if (is_digit(h) || ((h == CH_DOT) && has_next && is_digit(nx))) begin
          r.cnt = 2'd1;
          r.it0 = make_tok(h, KIND_NUMBER, 1'b1, !num_more);
          if (num_more) begin
            r.mode = MODE_NUM;
            r.dot  = (h == CH_DOT);
          end
        end else if (is_alpha(h) || (h == CH_UNDER)) begin
          r.cnt = 2'd1;
          r.it0 = make_tok(h, KIND_IDENT, 1'b1, !id_more);
          if (id_more) r.mode = MODE_ID;
        end else begin
          r.err = ERR_CHAR;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/expression_lexer_stream.sv -----
`timescale 1ns / 1ps
// Streaming lexer for arithmetic expression text, one byte per transfer.
//
// Usage: text bytes arrive on the text channel (text_valid, text_stall, text_byte,
// text_last), with text_last on the final byte of each text. Each token character
// leaves on the result channel (result_valid, result_stall and the token fields)
// as one transfer, marked with its kind and with start and end flags. An error
// transfer carries a nonzero error_code; the rest of that text is ignored and
// the receiver must drop the tokens it already got for that text.
// Throughput: one byte per cycle while the result queue has room. Each byte is
// registered, then lexed into a four-entry result queue; a byte is processed
// only while the queue has two free slots, since one byte can yield two results.
// Lookahead: a character is emitted only once the following byte is seen, one
// byte of lookahead. After the transfer of that following byte (or of the final
// byte) the result passes through the input register and is written into the
// queue, from which it is offered to the receiver.
// Stalls: when the receiver stalls, the queue fills and text_stall rises, so no
// byte or result is ever lost. Reset empties the input register and the queue
// and returns the scanner to the state between tokens.
module expression_lexer_stream
  import elx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       text_last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       token_valid,
  output logic [7:0] token_char,
  output logic [1:0] token_kind,
  output logic       token_start,
  output logic       token_end,
  output logic [1:0] error_code,
  output logic       text_end,
  output logic       run_last
);

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;

  // Scanner state.
  logic [7:0] held_char;
  logic       held_valid;
  scan_mode_t scan_mode;
  logic       dot_seen;
  logic       error_hold;

  // Result queue.
  res_item_t        res_mem [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic       process;
  logic       text_xfer;
  logic       pop;
  lex_res_t   r1;
  lex_res_t   r2;
  logic       hv2;
  scan_mode_t mode1;
  logic       dot1;
  logic [1:0] err1;
  logic [1:0] cnt1;
  logic       use2;
  logic [1:0] err_all;
  res_item_t  it0;
  res_item_t  it1;
  res_item_t  err_item;
  logic [1:0] n_res;
  logic [1:0] push_n;
  res_item_t  head;

  // A registered byte is processed when the queue can take two more results.
  assign process    = in_full && (count <= CNT_W'(RES_DEPTH - 2));
  assign text_stall = in_full && !process;
  assign text_xfer  = text_valid && !text_stall;
  assign pop        = result_valid && !result_stall;

  // First the held character is lexed with the new byte as lookahead; on the
  // final byte the new byte itself is then lexed with no lookahead.
  assign r1    = lex_char(scan_mode, dot_seen, held_char, 1'b1, in_byte);
  assign hv2   = held_valid ? !r1.ate : 1'b1;
  assign mode1 = held_valid ? r1.mode : scan_mode;
  assign dot1  = held_valid ? r1.dot : dot_seen;
  assign err1  = held_valid ? r1.err : ERR_NONE;
  assign cnt1  = held_valid ? r1.cnt : 2'd0;
  assign use2  = (err1 == ERR_NONE) && in_last && hv2;
  assign r2    = lex_char(mode1, dot1, in_byte, 1'b0, 8'h00);

  always_comb begin
    if (err1 != ERR_NONE) begin
      err_all = err1;
    end else if (use2) begin
      err_all = r2.err;
    end else begin
      err_all = ERR_NONE;
    end
  end

  always_comb begin
    err_item     = '0;
    err_item.err = err_all;
    it0          = '0;
    it1          = '0;
    n_res        = 2'd0;
    if (error_hold) begin
      // Only the final byte of a failed text yields anything: a bare end item.
      if (in_last) n_res = 2'd1;
    end else begin
      if (cnt1 != 2'd0) begin
        it0   = r1.it0;
        it1   = r1.it1;
        n_res = cnt1;
      end
      if (use2 && (r2.cnt != 2'd0)) begin
        if (n_res == 2'd0) begin
          it0 = r2.it0;
        end else begin
          it1 = r2.it0;
        end
        n_res = n_res + 2'd1;
      end
      if (err_all != ERR_NONE) begin
        if (n_res == 2'd0) begin
          it0 = err_item;
        end else begin
          it1 = err_item;
        end
        n_res = n_res + 2'd1;
      end
      if (in_last && (n_res == 2'd0)) n_res = 2'd1;
    end
    if (n_res == 2'd2) begin
      it1.rlast = 1'b1;
      it1.tend  = in_last;
    end else begin
      it0.rlast = 1'b1;
      it0.tend  = in_last;
    end
  end

  assign push_n = process ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (text_xfer) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
    if (text_xfer) begin
      in_byte <= text_byte;
      in_last <= text_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char  <= 8'h00;
      held_valid <= 1'b0;
      scan_mode  <= MODE_IDLE;
      dot_seen   <= 1'b0;
      error_hold <= 1'b0;
    end else if (process) begin
      if (in_last) begin
        // End of text: everything returns to the state after reset.
        held_char  <= 8'h00;
        held_valid <= 1'b0;
        scan_mode  <= MODE_IDLE;
        dot_seen   <= 1'b0;
        error_hold <= 1'b0;
      end else if (error_hold) begin
        error_hold <= 1'b1;
      end else if (err_all != ERR_NONE) begin
        held_char  <= 8'h00;
        held_valid <= 1'b0;
        scan_mode  <= MODE_IDLE;
        dot_seen   <= 1'b0;
        error_hold <= 1'b1;
      end else begin
        held_char  <= in_byte;
        held_valid <= hv2;
        scan_mode  <= mode1;
        dot_seen   <= dot1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
    if (push_n != 2'd0) res_mem[wr_ptr] <= it0;
    if (push_n == 2'd2) res_mem[wr_ptr + PTR_W'(1)] <= it1;
  end

  assign head         = res_mem[rd_ptr];
  assign result_valid = (count != '0);
  assign token_valid  = head.tok_valid;
  assign token_char   = head.ch;
  assign token_kind   = head.kind;
  assign token_start  = head.tok_start;
  assign token_end    = head.tok_end;
  assign error_code   = head.err;
  assign text_end     = head.tend;
  assign run_last     = head.rlast;

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RES_DEPTH))
    else $error("result queue count exceeds its depth");

  // The end of a text is always the last result of its byte.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && text_end) |-> run_last)
    else $error("text_end on a result that is not the last of its byte");

  // An error result never carries a token character.
  a_err_no_tok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (error_code != ERR_NONE)) |-> !token_valid)
    else $error("error result marked as token character");

  // After the final byte of a text, the scanner is back between tokens.
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (process && in_last) |=> (!held_valid && !error_hold && (scan_mode == MODE_IDLE)))
    else $error("scanner state not cleared at end of text");

endmodule

// ----- tb/lexer_token_checker.sv -----
`timescale 1ns / 1ps
// Watches both channels of the lexer, predicts every token transfer and compares it.
module lexer_token_checker
  import elx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  input  logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       text_last,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic       token_valid,
  input  logic [7:0] token_char,
  input  logic [1:0] token_kind,
  input  logic       token_start,
  input  logic       token_end,
  input  logic [1:0] error_code,
  input  logic       text_end,
  input  logic       run_last,
  output int         mismatch_count,
  output int         expected_count
);

  // Lexer state as the design should hold it.
  logic [7:0] held_char  = '0;
  logic       held_valid = 1'b0;
  scan_mode_t lex_mode   = MODE_IDLE;
  logic       dot_seen   = 1'b0;
  logic       error_hold = 1'b0;

  res_item_t  byte_results[2];
  int         byte_result_n;
  res_item_t  expected_tokens[$];

  initial mismatch_count = 0;
  initial expected_count = 0;

  function automatic logic digit_char(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic letter_char(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic word_char(logic [7:0] c);
    return letter_char(c) || digit_char(c) || (c == CH_UNDER);
  endfunction

  function automatic logic number_char(logic [7:0] c);
    return digit_char(c) || (c == CH_DOT);
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic operator_char(logic [7:0] c);
    return (c == "(") || (c == ")") || (c == "+") || (c == "-") || (c == CH_STAR) ||
           (c == "/") || (c == "^") || (c == "=") || (c == ",") || (c == "!");
  endfunction

  function automatic void push_result(logic tv, logic [7:0] c, logic [1:0] kind,
                                      logic first, logic closing, logic [1:0] err);
    res_item_t r;
    r           = '0;
    r.tok_valid = tv;
    r.ch        = c;
    r.kind      = kind;
    r.tok_start = first;
    r.tok_end   = closing;
    r.err       = err;
    byte_results[byte_result_n] = r;
    byte_result_n++;
  endfunction

  function automatic void clear_lexer();
    held_char  = '0;
    held_valid = 1'b0;
    lex_mode   = MODE_IDLE;
    dot_seen   = 1'b0;
    error_hold = 1'b0;
  endfunction

  // Lexes character h with optional lookahead nx; err is nonzero when h is rejected.
  task automatic scan_char(input logic [7:0] h, input logic has_next, input logic [7:0] nx,
                           output logic [1:0] err, output logic ate);
    logic more;
    err = ERR_NONE;
    ate = 1'b0;
    if (lex_mode == MODE_NUM) begin
      if ((h == CH_DOT) && dot_seen) begin
        err = ERR_DOTS;
      end else begin
        if (h == CH_DOT) dot_seen = 1'b1;
        more = has_next && number_char(nx);
        push_result(1'b1, h, KIND_NUMBER, 1'b0, !more, ERR_NONE);
        if (!more) begin
          lex_mode = MODE_IDLE;
          dot_seen = 1'b0;
        end
      end
    end else if (lex_mode == MODE_ID) begin
      more = has_next && word_char(nx);
      push_result(1'b1, h, KIND_IDENT, 1'b0, !more, ERR_NONE);
      if (!more) lex_mode = MODE_IDLE;
    end else if (blank_char(h)) begin
      // Blanks only separate tokens.
    end else if ((h == CH_STAR) && has_next && (nx == CH_STAR)) begin
      push_result(1'b1, CH_STAR, KIND_DSTAR, 1'b1, 1'b0, ERR_NONE);
      push_result(1'b1, CH_STAR, KIND_DSTAR, 1'b0, 1'b1, ERR_NONE);
      ate = 1'b1;
    end else if (operator_char(h)) begin
      push_result(1'b1, h, KIND_OP, 1'b1, 1'b1, ERR_NONE);
    end else if (digit_char(h) || ((h == CH_DOT) && has_next && digit_char(nx))) begin
      more = has_next && number_char(nx);
      push_result(1'b1, h, KIND_NUMBER, 1'b1, !more, ERR_NONE);
      if (more) begin
        lex_mode = MODE_NUM;
        dot_seen = (h == CH_DOT);
      end
    end else if (letter_char(h) || (h == CH_UNDER)) begin
      more = has_next && word_char(nx);
      push_result(1'b1, h, KIND_IDENT, 1'b1, !more, ERR_NONE);
      if (more) lex_mode = MODE_ID;
    end else begin
      err = ERR_CHAR;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic is_last);
    logic [1:0] err;
    logic       ate;
    byte_result_n = 0;
    err           = ERR_NONE;
    ate           = 1'b0;
    if (error_hold) begin
      if (is_last) begin
        push_result(1'b0, 8'h00, KIND_OP, 1'b0, 1'b0, ERR_NONE);
        clear_lexer();
      end
    end else begin
      if (held_valid) begin
        scan_char(held_char, 1'b1, b, err, ate);
        if (ate) begin
          held_valid = 1'b0;
        end else begin
          held_char  = b;
          held_valid = 1'b1;
        end
      end else begin
        held_char  = b;
        held_valid = 1'b1;
      end
      if ((err == ERR_NONE) && is_last && held_valid) begin
        scan_char(held_char, 1'b0, 8'h00, err, ate);
        held_valid = 1'b0;
      end
      if (err != ERR_NONE) begin
        push_result(1'b0, 8'h00, KIND_OP, 1'b0, 1'b0, err);
        clear_lexer();
        error_hold = 1'b1;
      end
      if (is_last) begin
        if (byte_result_n == 0) push_result(1'b0, 8'h00, KIND_OP, 1'b0, 1'b0, ERR_NONE);
        clear_lexer();
      end
    end
    if (byte_result_n > 0) begin
      if (is_last) byte_results[byte_result_n - 1].tend = 1'b1;
      byte_results[byte_result_n - 1].rlast = 1'b1;
    end
    for (int i = 0; i < byte_result_n; i++) begin
      expected_tokens.insert(expected_tokens.size(), byte_results[i]);
    end
  endtask

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      clear_lexer();
      expected_tokens.delete();
    end else begin
      if (text_valid && !text_stall) predict_byte(text_byte, text_last);
      if (result_valid && !result_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("token_char: expected no transfer, got %0h", token_char);
          mismatch_count++;
        end else begin
          want = expected_tokens.pop_front();
          compare_field("token_valid", 8'(want.tok_valid), 8'(token_valid));
          compare_field("token_char", want.ch, token_char);
          compare_field("token_kind", 8'(want.kind), 8'(token_kind));
          compare_field("token_start", 8'(want.tok_start), 8'(token_start));
          compare_field("token_end", 8'(want.tok_end), 8'(token_end));
          compare_field("error_code", 8'(want.err), 8'(error_code));
          compare_field("text_end", 8'(want.tend), 8'(text_end));
          compare_field("run_last", 8'(want.rlast), 8'(run_last));
        end
      end
    end
    expected_count <= expected_tokens.size();
  end

endmodule

// ----- tb/expression_lexer_stream_tb.sv -----
`timescale 1ns / 1ps
// Top of the lexer testbench: clock, reset, text stimulus, receiver stalls and verdict.
module expression_lexer_stream_tb
  import elx_pkg::*;
();

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       text_valid   = 1'b0;
  logic [7:0] text_byte    = 8'h00;
  logic       text_last    = 1'b0;
  logic       result_stall = 1'b0;

  logic       text_stall;
  logic       result_valid;
  logic       token_valid;
  logic [7:0] token_char;
  logic [1:0] token_kind;
  logic       token_start;
  logic       token_end;
  logic [1:0] error_code;
  logic       text_end;
  logic       run_last;

  int mismatch_count;
  int expected_count;

  // The stimulus bumps this counter to ask the receiver for one long hold-off.
  int long_hold_req  = 0;
  int long_hold_done = 0;

  int         bytes_sent  = 0;
  logic       sender_fast = 1'b0;
  logic [7:0] text_buf[$];

  string op_chars    = "()+-*/^=,!";
  string blank_chars = " \t\r\n";

  always #5 clk = ~clk;

  expression_lexer_stream dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .text_last   (text_last),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .token_valid (token_valid),
    .token_char  (token_char),
    .token_kind  (token_kind),
    .token_start (token_start),
    .token_end   (token_end),
    .error_code  (error_code),
    .text_end    (text_end),
    .run_last    (run_last)
  );

  lexer_token_checker token_check (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_stall    (text_stall),
    .text_byte     (text_byte),
    .text_last     (text_last),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .token_valid   (token_valid),
    .token_char    (token_char),
    .token_kind    (token_kind),
    .token_start   (token_start),
    .token_end     (token_end),
    .error_code    (error_code),
    .text_end      (text_end),
    .run_last      (run_last),
    .mismatch_count(mismatch_count),
    .expected_count(expected_count)
  );

  // Receiver. After every result transfer it draws how many cycles to stall
  // before taking the next one. Now and then it switches into a fast stretch
  // with no stalls at all. A long hold-off request overrides everything and
  // keeps the result channel blocked, so that the result queue fills and the
  // lexer has to push back on the text channel.
  always @(posedge clk) begin
    int stall_left;
    int fast_left;
    if (rst) begin
      stall_left = 0;
      fast_left  = 0;
      result_stall <= 1'b0;
    end else if (long_hold_req != long_hold_done) begin
      long_hold_done = long_hold_req;
      stall_left     = 300;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= (stall_left > 0);
    end else if (result_valid && !result_stall) begin
      if (fast_left > 0) begin
        fast_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        fast_left = $urandom_range(20, 60);
      end
      stall_left = (fast_left > 0) ? 0 : $urandom_range(0, 15);
      result_stall <= (stall_left > 0);
    end
  end

  // Appends one byte to the text buffer.
  function automatic void append_byte(logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  // Maps 0..62 onto the characters allowed inside an identifier.
  function automatic logic [7:0] word_byte(int k);
    if (k < 26) return 8'(int'("a") + k);
    if (k < 52) return 8'(int'("A") + k - 26);
    if (k < 62) return 8'(int'("0") + k - 52);
    return CH_UNDER;
  endfunction

  function automatic void load_string(string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  // Sends the buffered text, one transfer per byte, with text_last on the final
  // byte. Before each byte the sender idles for a random number of cycles unless
  // it is in a fast stretch. A byte counts as sent at the edge where valid is
  // high and text_stall is low; valid stays up across back-to-back transfers.
  task automatic send_text();
    int gap;
    foreach (text_buf[i]) begin
      gap = sender_fast ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        text_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      text_valid <= 1'b1;
      text_byte  <= text_buf[i];
      text_last  <= (i == text_buf.size() - 1);
      @(posedge clk);
      while (text_stall) @(posedge clk);
      bytes_sent++;
    end
  endtask

  // Drops valid and waits until the receiver has taken every predicted result.
  task automatic wait_drained();
    text_valid <= 1'b0;
    do @(posedge clk); while (expected_count != 0);
  endtask

  // Builds one random text. Most texts are well-formed token sequences with
  // random blanks between them; some carry one fault (a stray dot, a number
  // with two dots or an arbitrary byte), and a few are pure byte noise.
  task automatic compose_text();
    int   n_tok;
    int   fault_at;
    int   pick;
    int   len;
    int   dot_pos;
    logic broken;
    text_buf.delete();
    if ($urandom_range(0, 19) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) append_byte(8'($urandom_range(0, 255)));
    end else begin
      n_tok    = $urandom_range(1, 12);
      broken   = ($urandom_range(0, 4) == 0);
      fault_at = $urandom_range(0, n_tok - 1);
      for (int k = 0; k < n_tok; k++) begin
        pick = (broken && (k == fault_at)) ? 10 + $urandom_range(0, 2) : $urandom_range(0, 9);
        case (pick)
          0, 1, 2: begin
            // Number; a single dot may lead, sit inside or trail.
            len     = $urandom_range(1, 4);
            dot_pos = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : -1;
            for (int j = 0; j <= len; j++) begin
              if (j == dot_pos) append_byte(CH_DOT);
              if (j < len) append_byte(8'(int'("0") + $urandom_range(0, 9)));
            end
          end
          3, 4, 5: begin
            len = $urandom_range(0, 4);
            pick = $urandom_range(0, 52);
            append_byte(word_byte((pick == 52) ? 62 : pick));
            repeat (len) append_byte(word_byte($urandom_range(0, 62)));
          end
          6, 7, 8: append_byte(op_chars[$urandom_range(0, 9)]);
          9: begin
            append_byte(CH_STAR);
            append_byte(CH_STAR);
          end
          10: append_byte(CH_DOT);
          11: append_byte(8'($urandom_range(0, 255)));
          default: begin
            // Number with a second dot.
            append_byte(8'(int'("0") + $urandom_range(0, 9)));
            append_byte(CH_DOT);
            repeat ($urandom_range(0, 2)) append_byte(8'(int'("0") + $urandom_range(0, 9)));
            append_byte(CH_DOT);
            repeat ($urandom_range(0, 2)) append_byte(8'(int'("0") + $urandom_range(0, 9)));
          end
        endcase
        if ($urandom_range(0, 2) == 0) append_byte(blank_chars[$urandom_range(0, 3)]);
      end
    end
  endtask

  initial begin
    int text_count;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed texts. The first mixes an identifier with an underscore and a
    // digit, a number that opens with a dot, parentheses, a double star and a
    // number closed by the end of text.
    load_string("(a_1+.5)**x^2");
    send_text();
    // The remaining single operators, a lone star before a tab, and an
    // identifier that only the final byte closes.
    load_string("-/=,!*\tZ");
    send_text();
    // A second dot on the final byte: the error transfer itself carries text_end.
    load_string("9..");
    send_text();
    // A dot with no digit after it is an unexpected character; the NUL and the
    // 0xFF byte after it are ignored, and the final byte yields a bare end.
    text_buf = '{CH_DOT, 8'h00, 8'hFF};
    send_text();
    // Blanks only: nothing but a bare end transfer.
    load_string(" \r\n");
    send_text();

    // Random texts. Two long receiver hold-offs are requested while the
    // sender keeps streaming at full rate, and every thirtieth text the
    // sender waits until the result channel has delivered everything.
    text_count = 0;
    while (bytes_sent < 1730) begin
      if ((text_count == 15) || (text_count == 70)) begin
        long_hold_req <= long_hold_req + 1;
        sender_fast = 1'b1;
      end else begin
        sender_fast = ($urandom_range(0, 4) == 0);
      end
      compose_text();
      send_text();
      if ((text_count % 30) == 29) wait_drained();
      text_count++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(6_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/elx_pkg.sv
hw/rtl/expression_lexer_stream.sv
tb/lexer_token_checker.sv
tb/expression_lexer_stream_tb.sv
